FILE: hdl/asee_pkg.sv
// ----------------------------------------------------------------------------
// asee_pkg
// Shared types and constants for the add/subtract expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package asee_pkg;

    // Default nesting capacity of the bracket stack.
    localparam int STACK_DEPTH_DEF = 16;

    // Width of the arithmetic value.
    localparam int VALUE_W = 32;

    // Character codes that the evaluator decodes.
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Input request: one expression character.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } in_item_t;

    // Output request: the expression result.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      error;
    } out_item_t;

    // One saved level of the bracket stack.
    typedef struct packed {
        logic               subtract;
        logic [VALUE_W-1:0] sum;
    } stack_entry_t;

endpackage : asee_pkg

`default_nettype wire

FILE: hdl/add_sub_expression_evaluator.sv
// ----------------------------------------------------------------------------
// add_sub_expression_evaluator
// Evaluates a streamed infix expression of decimal numbers, plus, minus and
// parentheses, one character per request, and emits the wrapped 32-bit sum.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, back-to-back brackets too, but a last
// character stalls on a full output slot. Its result is valid the cycle after.
// The bracket stack lives in a RAM whose top entry is read ahead every cycle;
// a bypass register covers a pop that follows a push directly.
// Reset clears the sums, depth, error flag and output; the stack RAM is not
// cleared, since an entry is only read after it has been pushed.
`default_nettype none

module add_sub_expression_evaluator
    import asee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENTRY_W = $bits(stack_entry_t);

    // Evaluation state.
    logic [VALUE_W-1:0] sum_reg, sum_next;
    logic [VALUE_W-1:0] operand_reg, operand_next;
    logic               subtract_reg, subtract_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               error_reg, error_next;

    // Output slot.
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // Stack RAM access.
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    stack_entry_t       wr_entry;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               fwd_valid_reg;
    stack_entry_t       fwd_entry_reg;
    stack_entry_t       top_entry;

    logic               s_fire;
    logic [VALUE_W-1:0] folded;
    logic [VALUE_W-1:0] final_value;
    logic [3:0]         digit;
    logic               is_digit;

    // A character without last never produces a result, so it may pass a
    // waiting output.
    assign s_ready = !m_valid_reg || m_ready || !s_data.last;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Top of stack: RAM read-ahead, or the entry pushed in the previous cycle.
    assign top_entry = fwd_valid_reg ? fwd_entry_reg : stack_entry_t'(rd_data);

    // Fold the current operand into the running sum.
    assign folded = subtract_reg ? (sum_reg - operand_reg) : (sum_reg + operand_reg);

    assign digit    = 4'(s_data.character - CHAR_ZERO);
    assign is_digit = (s_data.character >= CHAR_ZERO) && (s_data.character <= CHAR_NINE);

    // Character decode and next-state logic.
    always_comb begin
        sum_next      = sum_reg;
        operand_next  = operand_reg;
        subtract_next = subtract_reg;
        depth_next    = depth_reg;
        error_next    = error_reg;
        wr_en         = 1'b0;
        wr_addr       = depth_reg[ADDR_W-1:0];
        wr_entry      = '{subtract: subtract_reg, sum: folded};
        final_value   = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (s_fire) begin
            if (s_data.character == CHAR_SPACE) begin
                // Spaces are skipped.
            end else if (is_digit) begin
                operand_next = {operand_reg[VALUE_W-4:0], 3'b000}
                             + {operand_reg[VALUE_W-2:0], 1'b0}
                             + VALUE_W'(digit);
            end else if (s_data.character == CHAR_OPEN) begin
                operand_next  = '0;
                subtract_next = 1'b0;
                if (depth_reg < DEPTH_W'(STACK_DEPTH)) begin
                    wr_en      = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                    sum_next   = '0;
                end else begin
                    // Stack overflow acts as a plain add operator.
                    sum_next   = folded;
                    error_next = 1'b1;
                end
            end else if (s_data.character == CHAR_CLOSE) begin
                operand_next = folded;
                if (depth_reg != '0) begin
                    depth_next    = depth_reg - DEPTH_W'(1);
                    sum_next      = top_entry.sum;
                    subtract_next = top_entry.subtract;
                end else begin
                    // Unmatched closing parenthesis restarts the outer sum.
                    sum_next      = '0;
                    subtract_next = 1'b0;
                end
            end else begin
                // Any other byte is an operator; only minus subtracts.
                sum_next      = folded;
                operand_next  = '0;
                subtract_next = (s_data.character == CHAR_MINUS);
            end

            // Final character: fold once more, emit, and restart.
            if (s_data.last) begin
                final_value        = subtract_next ? (sum_next - operand_next)
                                                   : (sum_next + operand_next);
                m_valid_next       = 1'b1;
                m_data_next.value  = final_value;
                m_data_next.error  = error_next || (depth_next != '0);
                sum_next           = '0;
                operand_next       = '0;
                subtract_next      = 1'b0;
                depth_next         = '0;
                error_next         = 1'b0;
            end
        end

        // Read ahead the entry that will be on top in the next cycle.
        if (depth_next == '0) begin
            rd_addr = '0;
        end else begin
            rd_addr = ADDR_W'(depth_next - DEPTH_W'(1));
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            operand_reg   <= '0;
            subtract_reg  <= 1'b0;
            depth_reg     <= '0;
            error_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            operand_reg   <= operand_next;
            subtract_reg  <= subtract_next;
            depth_reg     <= depth_next;
            error_reg     <= error_next;
            m_valid_reg   <= m_valid_next;
            fwd_valid_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        fwd_entry_reg <= wr_entry;
    end

    // Bracket stack.
    asee_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The nesting depth never exceeds the stack capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // A final character is only taken when the output slot can hold its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last) |-> (!m_valid_reg || m_ready))
        else $error("result accepted into a full output slot");

    // A push that is not on the final character deepens the stack by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !s_data.last) |=> (depth_reg == $past(depth_reg) + DEPTH_W'(1)))
        else $error("push did not advance the stack depth");

    // The bypass is only armed by a write in the previous cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> $past(wr_en))
        else $error("stack bypass without a preceding push");

endmodule : add_sub_expression_evaluator

`default_nettype wire

FILE: hdl/asee_ram.sv
// ----------------------------------------------------------------------------
// asee_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module asee_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a read of an address being written returns the old data.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule : asee_ram

`default_nettype wire

FILE: sim/tb_add_sub_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_add_sub_expression_evaluator
// Self-checking testbench for the streamed add/subtract expression evaluator.
// Characters go in one request at a time, and a local model of the evaluator
// predicts each result. The stimulus starts with short directed expressions
// and bracket nesting at the stack limit. A back-pressure burst follows, and
// then random expressions under several handshake idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_add_sub_expression_evaluator;
    import asee_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_PRINTS      = 20;
    localparam int PHASE_CHARS     = 110;

    typedef logic [7:0] char_q_t[$];

    typedef enum int {
        EXPR_CLEAN,
        EXPR_BROKEN,
        EXPR_NOISE
    } expr_style_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Evaluator state as predicted by the testbench.
    logic [VALUE_W-1:0] sum_acc;
    logic [VALUE_W-1:0] operand_acc;
    logic               subtract_pending;
    logic [VALUE_W-1:0] saved_sum [STACK_DEPTH_DEF];
    logic               saved_subtract [STACK_DEPTH_DEF];
    int                 open_depth;
    logic               overflow_seen;

    out_item_t expected_results[$];
    int mismatches    = 0;
    int chars_sent    = 0;
    int results_seen  = 0;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    add_sub_expression_evaluator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Return the predicted evaluator to its idle state.
    function automatic void clear_evaluator();
        sum_acc          = '0;
        operand_acc      = '0;
        subtract_pending = 1'b0;
        open_depth       = 0;
        overflow_seen    = 1'b0;
    endfunction

    // Apply the pending operator to the operand collected so far.
    function automatic void fold_operand();
        if (subtract_pending) begin
            sum_acc = sum_acc - operand_acc;
        end else begin
            sum_acc = sum_acc + operand_acc;
        end
        operand_acc = '0;
    endfunction

    // Advance the predicted state by one character; returns 1 with a result.
    function automatic bit evaluate_char(input in_item_t req, output out_item_t res);
        logic [VALUE_W-1:0] inner;
        logic [7:0]         c;
        c   = req.character;
        res = '0;
        if (c == CHAR_SPACE) begin
            // Spaces leave the state alone.
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            operand_acc = operand_acc * 10 + VALUE_W'(c - CHAR_ZERO);
        end else if (c == CHAR_OPEN) begin
            fold_operand();
            if (open_depth < STACK_DEPTH_DEF) begin
                saved_sum[open_depth]      = sum_acc;
                saved_subtract[open_depth] = subtract_pending;
                open_depth++;
                sum_acc = '0;
            end else begin
                overflow_seen = 1'b1;
            end
            subtract_pending = 1'b0;
        end else if (c == CHAR_CLOSE) begin
            fold_operand();
            inner = sum_acc;
            if (open_depth > 0) begin
                open_depth--;
                sum_acc          = saved_sum[open_depth];
                subtract_pending = saved_subtract[open_depth];
            end else begin
                sum_acc          = '0;
                subtract_pending = 1'b0;
            end
            operand_acc = inner;
        end else begin
            fold_operand();
            subtract_pending = (c == CHAR_MINUS);
        end

        if (!req.last) begin
            return 1'b0;
        end
        fold_operand();
        res.value = sum_acc;
        res.error = overflow_seen || (open_depth != 0);
        clear_evaluator();
        return 1'b1;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                     what, $signed(got), $signed(want), results_seen);
        end
        mismatches++;
    endtask

    // Offer one character request and record its prediction when it is taken.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int        gap;
        in_item_t  req;
        out_item_t res;
        gap = 0;
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct && gap < 8) begin
            gap++;
        end
        req.character = c;
        req.last      = is_last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        if (evaluate_char(req, res)) begin
            expected_results.push_back(res);
        end
        if (c != CHAR_SPACE) begin
            chars_sent++;
        end
    endtask

    // Send a whole expression, flagging its final character as last.
    task automatic send_seq(input char_q_t q);
        foreach (q[i]) begin
            send_char(q[i], i == q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        send_seq(q);
    endtask

    // Stop offering requests and let every predicted result come out.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Build one random expression of the given style.
    function automatic char_q_t build_expression(input expr_style_t style);
        char_q_t q;
        int      terms;
        int      ndig;
        int      open_lvls;
        int      max_open;
        int      pick;
        open_lvls = 0;
        max_open  = (style == EXPR_CLEAN) ? STACK_DEPTH_DEF : STACK_DEPTH_DEF + 3;
        if (style == EXPR_NOISE) begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(255)));
            return q;
        end
        terms = $urandom_range(1, 6);
        for (int t = 0; t < terms; t++) begin
            if ($urandom_range(9) < 2) begin
                q.push_back(CHAR_SPACE);
            end
            while ($urandom_range(9) < 3 && open_lvls < max_open) begin
                q.push_back(CHAR_OPEN);
                open_lvls++;
            end
            // Long digit runs can make the operand wrap past 32 bits.
            ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            repeat (ndig) q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            if (open_lvls > 0 && $urandom_range(9) < 3) begin
                q.push_back(CHAR_CLOSE);
                open_lvls--;
            end
            if (t < terms - 1) begin
                q.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            end
        end
        if (style == EXPR_CLEAN) begin
            repeat (open_lvls) q.push_back(CHAR_CLOSE);
            return q;
        end
        // Broken expressions can leave brackets open and gain stray tokens.
        repeat ($urandom_range(open_lvls)) q.push_back(CHAR_CLOSE);
        repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(4);
            case (pick)
                0: q.insert($urandom_range(q.size()), 8'(CHAR_ZERO + $urandom_range(9)));
                1: q.insert($urandom_range(q.size()), CHAR_OPEN);
                2: q.insert($urandom_range(q.size()), CHAR_CLOSE);
                3: q.insert($urandom_range(q.size()), CHAR_SPACE);
                default: q.insert($urandom_range(q.size()), 8'($urandom_range(255)));
            endcase
        end
        return q;
    endfunction

    // Short directed expressions covering each character class and corner.
    task automatic test_directed_cases();
        char_q_t q;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_text(" ");
        send_text("8+2");
        send_text("2(3)");
        send_text("(1)2");
        send_text("5)7");
        send_text("(4-");
        // Bytes at both ends of the range act as plain add operators.
        q = '{"9", 8'hFF, "3", 8'h00, "1"};
        send_seq(q);
        wait_for_results();
    endtask

    // Nesting at the full stack depth, one level beyond it, and left open.
    task automatic test_stack_limit();
        char_q_t q;
        for (int lvl = STACK_DEPTH_DEF; lvl <= STACK_DEPTH_DEF + 1; lvl++) begin
            q = {};
            repeat (lvl) q.push_back(CHAR_OPEN);
            q.push_back("1");
            repeat (lvl) q.push_back(CHAR_CLOSE);
            send_seq(q);
        end
        q = {};
        repeat (STACK_DEPTH_DEF) q.push_back(CHAR_OPEN);
        q.push_back("6");
        send_seq(q);
        wait_for_results();
    endtask

    // Hold the result side off while single-character expressions keep coming.
    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_len     = 150;
        hold_seq++;
        for (int i = 0; i < 30; i++) begin
            send_char(8'(CHAR_ZERO + $urandom_range(9)), 1'b1);
        end
        wait_for_results();
    endtask

    // Random expressions, mostly well formed, under the given idling mix.
    task automatic run_random_phase(input int gap_pct, input int stall_pct);
        int          start_count;
        int          r;
        expr_style_t style;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        start_count  = chars_sent;
        while (chars_sent - start_count < PHASE_CHARS) begin
            r     = $urandom_range(99);
            style = (r < 80) ? EXPR_CLEAN : (r < 92) ? EXPR_BROKEN : EXPR_NOISE;
            send_seq(build_expression(style));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(47, 0);
        run_random_phase(0, 47);
        run_random_phase(8, 8);
    endtask

    // Result side ready, with random stalls and an occasional long hold-off.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_data.value, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.value !== want.value) begin
                    report_mismatch("value", m_data.value, want.value);
                end
                if (m_data.error !== want.error) begin
                    report_mismatch("error flag", 32'(m_data.error), 32'(want.error));
                end
            end
            results_seen++;
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout: no request moved in %0d cycles", WATCHDOG_CYCLES);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        clear_evaluator();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_stack_limit();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d characters and checked %0d expression results.",
                 chars_sent, results_seen);
        $display("Covered directed corners, stack depth limit, back-pressure and idling mixes.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule : tb_add_sub_expression_evaluator

`default_nettype wire

FILE: sim.f
hdl/asee_pkg.sv
hdl/asee_ram.sv
hdl/add_sub_expression_evaluator.sv
sim/tb_add_sub_expression_evaluator.sv
